/* rtl/catmull_rom_path_eval_top_assert.svh */
// Assertion macros shared by the path evaluator RTL.
// Both expect clk_i in scope; CRPE_ASSERT also expects rst_ni.
`ifndef CATMULL_ROM_PATH_EVAL_TOP_ASSERT_SVH
`define CATMULL_ROM_PATH_EVAL_TOP_ASSERT_SVH

// Checked only while out of reset.
`define CRPE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define CRPE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/crpe_pkg.sv */
`default_nettype none

package crpe_pkg;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned COORD_W    = 32;
  // Horner accumulator: |c|+|b|+|a|+|2p1| < 24 * 2^31, plus sign
  localparam int unsigned ACC_W      = 37;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_EVAL   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_LOAD,
    ALU_MUL,
    ALU_ADD,
    ALU_HALF
  } alu_op_e;

  typedef struct packed {
    alu_op_e                   op;
    logic signed [ACC_W-1:0]   operand;
  } alu_cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] param_t;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [CNT_W-1:0]          points_held;
    logic                      point_dropped;
  } out_t;

endpackage

`default_nettype wire

/* rtl/crpe_ram.sv */
`default_nettype none

module crpe_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/crpe_alu.sv */
`default_nettype none

module crpe_alu #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire crpe_pkg::alu_cmd_t                    cmd_i,
  input  wire logic [FRAC_BITS:0]                    u_i,
  output logic signed [crpe_pkg::ACC_W-1:0]          acc_o,
  output logic signed [crpe_pkg::ACC_W+FRAC_BITS+1:0] prod_o
);

  import crpe_pkg::*;

  localparam int unsigned PROD_W = ACC_W + FRAC_BITS + 2;
  localparam logic signed [PROD_W-1:0] RND     = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  ACC_ONE = ACC_W'(1);

  logic signed [ACC_W-1:0]     acc_q, acc_d;
  logic signed [PROD_W-1:0]    prod_q, prod_d;
  logic signed [FRAC_BITS+1:0] u_s;
  logic signed [PROD_W-1:0]    rnd_sum;
  logic signed [PROD_W-1:0]    rnd_shift;

  assign u_s       = {1'b0, u_i};
  // round half up: floor((p + half) / 2^F)
  assign rnd_sum   = prod_q + RND;
  assign rnd_shift = rnd_sum >>> FRAC_BITS;

  always_comb begin
    acc_d  = acc_q;
    prod_d = prod_q;
    unique case (cmd_i.op)
      ALU_NOP:  ;
      ALU_LOAD: acc_d  = cmd_i.operand;
      ALU_MUL:  prod_d = PROD_W'(acc_q) * PROD_W'(u_s);
      ALU_ADD:  acc_d  = $signed(rnd_shift[ACC_W-1:0]) + cmd_i.operand;
      ALU_HALF: acc_d  = $signed(acc_q + ACC_ONE) >>> 1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      prod_q <= '0;
    end else begin
      acc_q  <= acc_d;
      prod_q <= prod_d;
    end
  end

  assign acc_o  = acc_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* rtl/catmull_rom_path_eval_top.sv */
// Uniform Catmull-Rom path evaluator over a store of up to 64 3D points (Q16.16).
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction is an
// append, a clear or an evaluate at param_t. Output channel (out_valid_o /
// out_stall_i / out_data_o): exactly one result transaction per input.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): loop_mode bit,
// always ready; write it only while the block is idle.
// Sequence: append, clear, unused codes and evaluate on an empty store are
// accepted, then loaded into the result register. A full evaluate scales t by
// the segment count and splits off segment and local parameter, makes four
// reads on the one read port of the point memory, runs each axis on the one
// shared multiply/round/add unit (coefficient load, three Horner steps of
// multiply then add, halve, saturate), then loads the result.
// in_stall_o is high from acceptance until the result is loaded into the
// output register.
// Reset clears the point count, loop_mode and the output valid flag; the point
// memory is not cleared. A stalled receiver holds the result in the output
// register; a following result then waits and the input stays stalled.
`default_nettype none
`include "catmull_rom_path_eval_top_assert.svh"

module catmull_rom_path_eval_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire crpe_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output crpe_pkg::out_t       out_data_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic            cfg_data_i
);

  import crpe_pkg::*;

  localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(32'sh8000_0000);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEG_MUL,
    ST_SPLIT,
    ST_READ,
    ST_COEF,
    ST_MUL,
    ST_ADD,
    ST_HALF,
    ST_SAT,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  function automatic logic signed [COORD_W-1:0] coord(input point_t p, input axis_e a);
    logic signed [COORD_W-1:0] r;
    unique case (a)
      AXIS_X:  r = p.x;
      AXIS_Y:  r = p.y;
      AXIS_Z:  r = p.z;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end
    return r[COORD_W-1:0];
  endfunction

  // ---------------------------------------------------------------- state
  state_e                    state_q;
  axis_e                     axis_q;
  logic [CNT_W-1:0]          count_q;
  logic                      dropped_q;
  logic                      loop_mode_q;
  logic [FRAC_BITS:0]        tq_q;
  logic [FRAC_BITS:0]        u_q;
  logic [IDX_W-1:0]          idx_q [4];
  point_t                    pt_q [4];
  logic signed [ACC_W-1:0]   coef_q;
  logic [1:0]                step_q;
  logic [2:0]                rd_cnt_q;
  logic signed [COORD_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  out_t                      out_q;
  logic                      out_valid_q;

  // ---------------------------------------------------------------- handshakes
  logic in_accept;
  logic out_take;
  logic out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------- t clamp / wrap
  logic [FRAC_BITS:0] tq_in;

  always_comb begin
    if (loop_mode_q) begin
      // wrap: keep fraction bits only, negatives land in [0,1)
      tq_in = {1'b0, in_data_i.param_t[FRAC_BITS-1:0]};
    end else if (in_data_i.param_t[COORD_W-1]) begin
      tq_in = '0;
    end else if (in_data_i.param_t[COORD_W-2:0] > (COORD_W-1)'(ONE_Q)) begin
      tq_in = ONE_Q;
    end else begin
      tq_in = in_data_i.param_t[FRAC_BITS:0];
    end
  end

  // ---------------------------------------------------------------- point memory
  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  point_t           ram_wdata;
  point_t           ram_rdata;
  logic [2:0]       rd_prev;

  assign ram_we = in_accept && (in_data_i.action == ACT_APPEND) &&
                  (count_q < CNT_W'(MAX_POINTS));
  assign ram_wdata.x = in_data_i.point_x;
  assign ram_wdata.y = in_data_i.point_y;
  assign ram_wdata.z = in_data_i.point_z;
  assign ram_raddr   = idx_q[rd_cnt_q[1:0]];
  assign rd_prev     = rd_cnt_q - 3'd1;

  crpe_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- segment split
  logic [CNT_W-1:0]   segs;
  logic [CNT_W-1:0]   seg_raw, seg_sel, n_m1, s_p1, s_p2;
  logic [CNT_W-1:0]   nb [4];
  logic [FRAC_BITS:0] u_sel;

  logic signed [ACC_W-1:0]                acc;
  logic signed [ACC_W+FRAC_BITS+1:0]      prod;

  // loop mode has n segments, clamp mode n-1
  assign segs = loop_mode_q ? count_q : count_q - CNT_W'(1);

  always_comb begin
    seg_raw = prod[FRAC_BITS +: CNT_W];
    seg_sel = seg_raw;
    u_sel   = {1'b0, prod[FRAC_BITS-1:0]};
    if (count_q == CNT_W'(1)) begin
      // single point: equal neighbors at u = 0 give the point back exactly
      seg_sel = '0;
      u_sel   = '0;
    end else if (seg_raw >= segs) begin
      if (loop_mode_q) begin
        seg_sel = '0;
        u_sel   = '0;
      end else begin
        // t at one: end of last segment
        seg_sel = segs - CNT_W'(1);
        u_sel   = ONE_Q;
      end
    end

    n_m1  = count_q - CNT_W'(1);
    s_p1  = seg_sel + CNT_W'(1);
    s_p2  = seg_sel + CNT_W'(2);
    nb[1] = seg_sel;
    if (loop_mode_q) begin
      nb[0] = (seg_sel == '0) ? n_m1 : seg_sel - CNT_W'(1);
      nb[2] = (s_p1 == count_q) ? '0 : s_p1;
      nb[3] = (s_p2 >= count_q) ? s_p2 - count_q : s_p2;
    end else begin
      nb[0] = (seg_sel == '0) ? '0 : seg_sel - CNT_W'(1);
      nb[2] = s_p1;
      nb[3] = (s_p2 > n_m1) ? n_m1 : s_p2;
    end
    if (count_q == CNT_W'(1)) begin
      nb[0] = '0;
      nb[2] = '0;
      nb[3] = '0;
    end
  end

  // ---------------------------------------------------------------- coefficients
  logic signed [COORD_W-1:0] p0, p1, p2, p3;
  logic signed [ACC_W-1:0]   e0, e1, e2, e3;
  logic signed [ACC_W-1:0]   coef_a, coef_b, coef_c, coef_d;

  assign p0 = coord(pt_q[0], axis_q);
  assign p1 = coord(pt_q[1], axis_q);
  assign p2 = coord(pt_q[2], axis_q);
  assign p3 = coord(pt_q[3], axis_q);
  assign e0 = ACC_W'(p0);
  assign e1 = ACC_W'(p1);
  assign e2 = ACC_W'(p2);
  assign e3 = ACC_W'(p3);

  // 0.5 * (2p1 + a*u + b*u^2 + c*u^3)
  assign coef_a = e2 - e0;
  assign coef_b = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign coef_c = (e3 - e0) + ((e1 - e2) <<< 1) + (e1 - e2);
  assign coef_d = e1 <<< 1;

  // ---------------------------------------------------------------- shared unit
  alu_cmd_t           alu_cmd;
  logic [FRAC_BITS:0] alu_u;

  always_comb begin
    alu_cmd.op      = ALU_NOP;
    alu_cmd.operand = coef_q;
    alu_u           = u_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (in_data_i.action == ACT_EVAL)) begin
          alu_cmd.op      = ALU_LOAD;
          alu_cmd.operand = ACC_W'(segs);
        end
      end
      ST_SEG_MUL: begin
        alu_cmd.op = ALU_MUL;
        alu_u      = tq_q;
      end
      ST_COEF: begin
        alu_cmd.op      = ALU_LOAD;
        alu_cmd.operand = coef_c;
      end
      ST_MUL:  alu_cmd.op = ALU_MUL;
      ST_ADD:  alu_cmd.op = ALU_ADD;
      ST_HALF: alu_cmd.op = ALU_HALF;
      default: ;
    endcase
  end

  crpe_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (alu_cmd),
    .u_i    (alu_u),
    .acc_o  (acc),
    .prod_o (prod)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AXIS_X;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      loop_mode_q <= 1'b0;
      tq_q        <= '0;
      u_q         <= '0;
      idx_q       <= '{default: '0};
      pt_q        <= '{default: '0};
      coef_q      <= '0;
      step_q      <= '0;
      rd_cnt_q    <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        loop_mode_q <= cfg_data_i;
      end

      // a new result may replace one taken at the same edge
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            pos_x_q   <= '0;
            pos_y_q   <= '0;
            pos_z_q   <= '0;
            dropped_q <= (in_data_i.action == ACT_APPEND) &&
                         !(count_q < CNT_W'(MAX_POINTS));
            if ((in_data_i.action == ACT_EVAL) && (count_q != '0)) begin
              tq_q    <= tq_in;
              state_q <= ST_SEG_MUL;
            end else begin
              state_q <= ST_FINISH;
            end
            unique case (in_data_i.action)
              ACT_APPEND: begin
                if (count_q < CNT_W'(MAX_POINTS)) begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              ACT_CLEAR: count_q <= '0;
              default: ;
            endcase
          end
        end
        ST_SEG_MUL: state_q <= ST_SPLIT;
        ST_SPLIT: begin
          u_q      <= u_sel;
          idx_q[0] <= nb[0][IDX_W-1:0];
          idx_q[1] <= nb[1][IDX_W-1:0];
          idx_q[2] <= nb[2][IDX_W-1:0];
          idx_q[3] <= nb[3][IDX_W-1:0];
          rd_cnt_q <= '0;
          state_q  <= ST_READ;
        end
        ST_READ: begin
          // read data arrives in the cycle after its address
          if (rd_cnt_q != '0) begin
            pt_q[rd_prev[1:0]] <= ram_rdata;
          end
          if (rd_cnt_q == 3'd4) begin
            axis_q  <= AXIS_X;
            state_q <= ST_COEF;
          end else begin
            rd_cnt_q <= rd_cnt_q + 3'd1;
          end
        end
        ST_COEF: begin
          coef_q  <= coef_b;
          step_q  <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: state_q <= ST_ADD;
        ST_ADD: begin
          step_q <= step_q + 2'd1;
          if (step_q == 2'd0) begin
            coef_q <= coef_a;
          end else begin
            coef_q <= coef_d;
          end
          state_q <= (step_q == 2'd2) ? ST_HALF : ST_MUL;
        end
        ST_HALF: state_q <= ST_SAT;
        ST_SAT: begin
          unique case (axis_q)
            AXIS_X: begin
              pos_x_q <= sat32(acc);
              axis_q  <= AXIS_Y;
              state_q <= ST_COEF;
            end
            AXIS_Y: begin
              pos_y_q <= sat32(acc);
              axis_q  <= AXIS_Z;
              state_q <= ST_COEF;
            end
            default: begin
              pos_z_q <= sat32(acc);
              state_q <= ST_FINISH;
            end
          endcase
        end
        ST_FINISH: begin
          if (out_free) begin
            out_q.pos_x         <= pos_x_q;
            out_q.pos_y         <= pos_y_q;
            out_q.pos_z         <= pos_z_q;
            out_q.points_held   <= count_q;
            out_q.point_dropped <= dropped_q;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  `CRPE_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_POINTS), "point count above store size")
  `CRPE_ASSERT(a_write_has_room, ram_we |-> (count_q < CNT_W'(MAX_POINTS)), "write into full store")
  `CRPE_ASSERT(a_result_from_finish, $rose(out_valid_q) |-> $past(state_q == ST_FINISH), "result loaded outside finish")
  `CRPE_ASSERT(a_local_u_range, (state_q == ST_READ) |-> (u_q <= ONE_Q), "local parameter above one")
  `CRPE_ASSERT_ALWAYS(a_cfg_always_ready, cfg_ready_o, "config channel not ready")

endmodule

`default_nettype wire
